>>> src/assert_macros.svh
// assertion macros for the circle and polygon overlap test
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// when trig holds, prop holds at the following edge
`define ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg)
`endif
`endif

>>> src/copt_pkg.sv
// shared types and constants of the circle and polygon overlap test
`timescale 1ns / 1ps
package copt_pkg;
	localparam int CW = 16;          // coordinate width
	localparam int RW = CW - 1;      // radius width
	localparam int DW = CW + 1;      // coordinate difference width
	localparam int PW = 2 * DW;      // product width
	localparam int SW = PW + 1;      // signed sum of two products
	localparam int QW = 2 * RW;      // squared radius width
	localparam int XW = 2 * PW;      // wide product width

	localparam logic KIND_CIRCLE = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_SUM,
		ST_WIDE,
		ST_CMP,
		ST_CLOSE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // take the input beat
		logic load;      // load edge operands and differences
		logic closing;   // edge runs from current vertex back to first
		logic commit;    // fold edge result into hit and parity
		logic advance;   // current vertex becomes previous
		logic result;    // write result register and end polygon
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic open_edge; // vertex closes an edge from the previous one
		logic last;      // vertex is the final one
		logic out_free;  // result register can take a new result
	} sts_t;
endpackage

>>> src/copt_ctrl.sv
// sequencer that walks each vertex through its edge computations
`timescale 1ns / 1ps
module copt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           kind,
	output logic           in_ready,
	input  copt_pkg::sts_t sts,
	output copt_pkg::cmd_t cmd
);
	import copt_pkg::*;

	state_t state_q, state_nx;
	logic   closing_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			closing_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load)
				closing_q <= cmd.closing;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && kind == KIND_VERTEX)
					state_nx = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.open_edge || sts.last)
					state_nx = ST_MUL;
				else
					state_nx = ST_IDLE;
			end
			ST_MUL:   state_nx = ST_SUM;
			ST_SUM:   state_nx = ST_WIDE;
			ST_WIDE:  state_nx = ST_CMP;
			ST_CMP: begin
				if (closing_q)
					state_nx = ST_OUT;
				else if (sts.last)
					state_nx = ST_CLOSE;
				else
					state_nx = ST_IDLE;
			end
			ST_CLOSE: state_nx = ST_MUL;
			ST_OUT: begin
				if (sts.out_free)
					state_nx = ST_IDLE;
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECIDE: begin
				cmd.load    = sts.open_edge || sts.last;
				cmd.closing = !sts.open_edge;
				cmd.advance = !(sts.open_edge || sts.last);
			end
			ST_CMP: begin
				cmd.commit  = 1'b1;
				cmd.advance = !closing_q && !sts.last;
			end
			ST_CLOSE: begin
				cmd.load    = 1'b1;
				cmd.closing = 1'b1;
			end
			ST_OUT: begin
				cmd.result  = sts.out_free;
				cmd.advance = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

>>> src/copt_dp.sv
// datapath: circle and vertex registers, edge distance and ray crossing arithmetic
`timescale 1ns / 1ps
module copt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kind,
	input  logic signed [copt_pkg::CW-1:0] x,
	input  logic signed [copt_pkg::CW-1:0] y,
	input  logic        [copt_pkg::RW-1:0] radius,
	input  logic                          last,
	input  copt_pkg::cmd_t                cmd,
	output copt_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          collides,
	output logic                          centre_inside
);
	import copt_pkg::*;

	// circle and polygon state
	logic signed [CW-1:0] cx_q, cy_q, cur_x_q, cur_y_q;
	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic        [RW-1:0] rad_q;
	logic                 have_vertex_q, open_edge_q, last_q, edge_hit_q, parity_q;
	logic                 out_valid_q, collides_q, inside_q;

	// stage 1: differences
	logic signed [DW-1:0] dx_s1, dy_s1, wx_s1, wy_s1, ex_s1, ey_s1;
	logic                 straddle_s1;
	// stage 2: products
	logic signed [PW-1:0] wxdx_s2, wydy_s2, dxdx_s2, dydy_s2, wxwx_s2, wywy_s2;
	logic signed [PW-1:0] exex_s2, eyey_s2, wxdy_s2, wydx_s2, exdy_s2, dxey_s2;
	logic        [QW-1:0] r2_s2;
	logic                 straddle_s2, dyneg_s2;
	// stage 3: sums and selection
	logic        [PW-1:0] den_s3, dw_s3, de_s3, cmag_s3;
	logic        [QW-1:0] r2_s3;
	logic                 near_a_s3, near_b_s3, cross_s3;
	// stage 4: wide products
	logic        [XW-1:0] crsq_s4, rden_s4;
	logic        [PW-1:0] dw_s4, de_s4;
	logic        [QW-1:0] r2_s4;
	logic                 near_a_s4, near_b_s4, cross_s4;

	logic signed [CW-1:0] ax, ay, bx, by;
	logic signed [SW-1:0] num, cr;
	logic        [PW-1:0] den;
	logic                 near;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q          <= '0;
			cy_q          <= '0;
			rad_q         <= '0;
			have_vertex_q <= 1'b0;
			open_edge_q   <= 1'b0;
			last_q        <= 1'b0;
			edge_hit_q    <= 1'b0;
			parity_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.result)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.capture) begin
				if (kind == KIND_CIRCLE) begin
					cx_q          <= x;
					cy_q          <= y;
					rad_q         <= radius;
					have_vertex_q <= 1'b0;
					edge_hit_q    <= 1'b0;
					parity_q      <= 1'b0;
				end else begin
					open_edge_q   <= have_vertex_q;
					last_q        <= last;
					have_vertex_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				edge_hit_q <= edge_hit_q | near;
				parity_q   <= parity_q ^ cross_s4;
			end
			if (cmd.result) begin
				have_vertex_q <= 1'b0;
				edge_hit_q    <= 1'b0;
				parity_q      <= 1'b0;
			end
		end
	end

	// vertex and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture && kind == KIND_VERTEX) begin
			cur_x_q <= x;
			cur_y_q <= y;
			if (!have_vertex_q) begin
				first_x_q <= x;
				first_y_q <= y;
			end
		end
		if (cmd.advance) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.result) begin
			collides_q <= edge_hit_q | parity_q;
			inside_q   <= parity_q;
		end
	end

	// edge endpoints
	always_comb begin
		if (cmd.closing) begin
			ax = cur_x_q;
			ay = cur_y_q;
			bx = first_x_q;
			by = first_y_q;
		end else begin
			ax = prev_x_q;
			ay = prev_y_q;
			bx = cur_x_q;
			by = cur_y_q;
		end
	end

	// edge pipeline; the controller loads stage 1, later stages are not gated
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_s1       <= DW'(bx) - DW'(ax);
			dy_s1       <= DW'(by) - DW'(ay);
			wx_s1       <= DW'(cx_q) - DW'(ax);
			wy_s1       <= DW'(cy_q) - DW'(ay);
			ex_s1       <= DW'(cx_q) - DW'(bx);
			ey_s1       <= DW'(cy_q) - DW'(by);
			straddle_s1 <= (by > cy_q) != (ay > cy_q);
		end
		wxdx_s2     <= wx_s1 * dx_s1;
		wydy_s2     <= wy_s1 * dy_s1;
		dxdx_s2     <= dx_s1 * dx_s1;
		dydy_s2     <= dy_s1 * dy_s1;
		wxwx_s2     <= wx_s1 * wx_s1;
		wywy_s2     <= wy_s1 * wy_s1;
		exex_s2     <= ex_s1 * ex_s1;
		eyey_s2     <= ey_s1 * ey_s1;
		wxdy_s2     <= wx_s1 * dy_s1;
		wydx_s2     <= wy_s1 * dx_s1;
		exdy_s2     <= ex_s1 * dy_s1;
		dxey_s2     <= dx_s1 * ey_s1;
		r2_s2       <= rad_q * rad_q;
		straddle_s2 <= straddle_s1;
		dyneg_s2    <= dy_s1[DW-1];

		den_s3    <= den;
		dw_s3     <= PW'(wxwx_s2) + PW'(wywy_s2);
		de_s3     <= PW'(exex_s2) + PW'(eyey_s2);
		cmag_s3   <= cr[SW-1] ? PW'(-cr) : PW'(cr);
		r2_s3     <= r2_s2;
		near_a_s3 <= (den == '0) || (num <= 0);
		near_b_s3 <= num >= $signed({1'b0, den});
		cross_s3  <= straddle_s2 && (dyneg_s2 ? (exdy_s2 > dxey_s2) : (exdy_s2 < dxey_s2));

		crsq_s4   <= cmag_s3 * cmag_s3;
		rden_s4   <= XW'(r2_s3) * XW'(den_s3);
		dw_s4     <= dw_s3;
		de_s4     <= de_s3;
		r2_s4     <= r2_s3;
		near_a_s4 <= near_a_s3;
		near_b_s4 <= near_b_s3;
		cross_s4  <= cross_s3;
	end

	// stage 3 sums
	always_comb begin
		num = SW'(wxdx_s2) + SW'(wydy_s2);
		cr  = SW'(wxdy_s2) - SW'(wydx_s2);
		den = PW'(dxdx_s2) + PW'(dydy_s2);
	end

	// nearest point of the segment within reach
	always_comb begin
		if (near_a_s4)
			near = dw_s4 <= PW'(r2_s4);
		else if (near_b_s4)
			near = de_s4 <= PW'(r2_s4);
		else
			near = crsq_s4 <= rden_s4;
	end

	assign sts.open_edge = open_edge_q;
	assign sts.last      = last_q;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign collides      = collides_q;
	assign centre_inside = inside_q;
endmodule

>>> src/circle_polygon_overlap_test.sv
// top level of the circle and polygon overlap test
//
// Input channel (in_valid/in_ready): a beat with kind = 0 loads the circle
// centre x, y and radius and abandons any polygon in progress. Beats with
// kind = 1 carry polygon vertices in order; last marks the final vertex.
// Output channel (out_valid/out_ready): one beat per polygon, after its last
// vertex, with collides (an edge within the radius, or centre inside) and
// centre_inside (ray parity of the centre).
// Sequencing: a circle beat is taken while idle. A vertex that closes an
// edge, or a first non-final vertex, is done before the next beat; a final
// vertex runs any open edge and its closing edge through the four-step pipeline
// (differences, products, sums, wide products), then its result is registered.
// The edge pipeline handles one edge at a time, so vertices are serial.
// The result sits in an output register; a stalled receiver holds it there
// while following vertices are taken, and only the next polygon's result
// waits for it to drain. Reset clears the circle to centre 0,0 radius 0
// and empties the polygon and the output register.
`timescale 1ns / 1ps
module circle_polygon_overlap_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic signed [copt_pkg::CW-1:0] x,
	input  logic signed [copt_pkg::CW-1:0] y,
	input  logic        [copt_pkg::RW-1:0] radius,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          collides,
	output logic                          centre_inside
);
	import copt_pkg::*;
	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// sequencer
	copt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and state
	copt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.kind          (kind),
		.x             (x),
		.y             (y),
		.radius        (radius),
		.last          (last),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.collides      (collides),
		.centre_inside (centre_inside)
	);

	// checks
	`ASSERT_HOLDS(a_inside_collides, clk, arst_n, !out_valid || !centre_inside || collides, "inside without collision")
	`ASSERT_NEXT(a_vertex_busy, clk, arst_n, in_valid && in_ready && kind == KIND_VERTEX, !in_ready, "vertex beat did not start work")
	`ASSERT_NEXT(a_circle_quick, clk, arst_n, in_valid && in_ready && kind == KIND_CIRCLE, in_ready, "circle beat stalled input")
endmodule
